/* design/assert_macros.svh */
// Assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/z85_pkg.sv */
// Types, constants and alphabet lookup shared by the Z85 decoder modules
package z85_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] NEWLINE   = 8'd10;
	localparam logic [6:0] BASE      = 7'd85;
	localparam logic [2:0] LAST_DIGIT = 3'd4;

	typedef enum logic [1:0] {
		ST_DATA     = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [6:0] val;
	} digit_t;

	// One finished group or one error, as handed from front to back
	typedef struct packed {
		status_t     status;
		logic [31:0] value;
	} event_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic digit_t z85_digit(input logic [7:0] ch);
		digit_t d;
		d.ok  = 1'b1;
		d.val = 7'd0;
		if (ch >= "0" && ch <= "9") begin
			d.val = 7'(ch - "0");
		end else if (ch >= "a" && ch <= "z") begin
			d.val = 7'(ch - "a" + 8'd10);
		end else if (ch >= "A" && ch <= "Z") begin
			d.val = 7'(ch - "A" + 8'd36);
		end else begin
			unique case (ch)
				".": d.val = 7'd62;
				"-": d.val = 7'd63;
				":": d.val = 7'd64;
				"+": d.val = 7'd65;
				"=": d.val = 7'd66;
				"^": d.val = 7'd67;
				"!": d.val = 7'd68;
				"/": d.val = 7'd69;
				"*": d.val = 7'd70;
				"?": d.val = 7'd71;
				"&": d.val = 7'd72;
				"<": d.val = 7'd73;
				">": d.val = 7'd74;
				"(": d.val = 7'd75;
				")": d.val = 7'd76;
				"[": d.val = 7'd77;
				"]": d.val = 7'd78;
				"{": d.val = 7'd79;
				"}": d.val = 7'd80;
				"@": d.val = 7'd81;
				"%": d.val = 7'd82;
				"$": d.val = 7'd83;
				"#": d.val = 7'd84;
				default: d.ok = 1'b0;
			endcase
		end
		return d;
	endfunction

endpackage

/* design/z85_front.sv */
// Front end: accepts characters, maps them to digits and folds groups of five
`include "assert_macros.svh"

module z85_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_in,
	input  z85_pkg::q_stat_t   q_stat,
	output logic               push,
	output z85_pkg::event_t    push_ev
);

	logic [25:0]      partial_q;
	logic [2:0]       count_q;
	z85_pkg::digit_t  dig;
	logic [32:0]      acc;
	logic             accept;
	logic             is_nl;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign is_nl    = (char_in == z85_pkg::NEWLINE);
	assign dig      = z85_pkg::z85_digit(char_in);
	assign acc      = {7'd0, partial_q} * {26'd0, z85_pkg::BASE} + {26'd0, dig.val};

	always_comb begin
		push           = 1'b0;
		push_ev.status = z85_pkg::ST_DATA;
		push_ev.value  = acc[31:0];
		if (accept && !is_nl) begin
			if (!dig.ok) begin
				push           = 1'b1;
				push_ev.status = z85_pkg::ST_BAD_CHAR;
				push_ev.value  = 32'd0;
			end else if (count_q == z85_pkg::LAST_DIGIT) begin
				push           = 1'b1;
				push_ev.status = acc[32] ? z85_pkg::ST_OVERFLOW : z85_pkg::ST_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			count_q   <= '0;
		end else if (accept && !is_nl) begin
			if (!dig.ok || count_q == z85_pkg::LAST_DIGIT) begin
				// clear the partial group after a bad character or a closed group
				partial_q <= '0;
				count_q   <= '0;
			end else begin
				partial_q <= acc[25:0];
				count_q   <= count_q + 3'd1;
			end
		end
	end

	`ASSERT_IMPL(a_count_range, 1'b1, count_q <= z85_pkg::LAST_DIGIT, "digit count past four")

endmodule

/* design/z85_queue.sv */
// Short event queue between the front and back ends
`include "assert_macros.svh"

module z85_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  z85_pkg::event_t  push_ev,
	input  logic             pop,
	output z85_pkg::event_t  head_ev,
	output z85_pkg::q_stat_t q_stat
);

	z85_pkg::event_t              entries_q [z85_pkg::QDEPTH];
	logic [z85_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [z85_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [z85_pkg::QCNT_W-1:0]   count_q;

	assign q_stat.full  = (count_q == z85_pkg::QCNT_W'(z85_pkg::QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head_ev      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_IMPL(a_no_overrun, push, !q_stat.full, "push into a full queue")
	`ASSERT_IMPL(a_no_underrun, pop, !q_stat.empty, "pop from an empty queue")

endmodule

/* design/z85_back.sv */
// Back end: expands queued events into output beats through an output register
`include "assert_macros.svh"

module z85_back (
	input  logic             clk,
	input  logic             arst_n,
	input  z85_pkg::event_t  head_ev,
	input  z85_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       byte_out,
	output logic             group_last,
	output logic [1:0]       status
);

	logic              out_valid_q;
	logic              busy_q;
	logic [1:0]        idx_q;
	logic [31:0]       word_q;
	logic [7:0]        byte_q;
	logic              last_q;
	z85_pkg::status_t  status_q;
	logic              slot_free;
	logic [7:0]        next_byte;

	assign slot_free  = !out_valid_q || out_ready;
	assign pop        = slot_free && !busy_q && !q_stat.empty;
	assign out_valid  = out_valid_q;
	assign byte_out   = byte_q;
	assign group_last = last_q;
	assign status     = status_q;

	always_comb begin
		case (idx_q)
			2'd1:    next_byte = word_q[23:16];
			2'd2:    next_byte = word_q[15:8];
			2'd3:    next_byte = word_q[7:0];
			default: next_byte = word_q[31:24];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
		end else if (slot_free) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 2'd1;
				busy_q      <= (idx_q != 2'd3);
			end else if (!q_stat.empty) begin
				out_valid_q <= 1'b1;
				idx_q       <= 2'd1;
				busy_q      <= (head_ev.status == z85_pkg::ST_DATA);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (busy_q) begin
				byte_q   <= next_byte;
				last_q   <= (idx_q == 2'd3);
				status_q <= z85_pkg::ST_DATA;
			end else if (!q_stat.empty) begin
				word_q   <= head_ev.value;
				status_q <= head_ev.status;
				if (head_ev.status == z85_pkg::ST_DATA) begin
					byte_q <= head_ev.value[31:24];
					last_q <= 1'b0;
				end else begin
					byte_q <= 8'd0;
					last_q <= 1'b1;
				end
			end
		end
	end

	`ASSERT_IMPL(a_err_is_last, out_valid_q && status_q != z85_pkg::ST_DATA, last_q, "error beat not last")
	`ASSERT_IMPL(a_busy_has_beat, busy_q, out_valid_q, "group in flight without a beat")

endmodule

/* design/z85_stream_decoder.sv */
// Top level of the Z85 stream decoder
// Decodes a Z85 character stream at one character per cycle: a character is
// taken every cycle while the four-entry event queue has room, and newline
// characters are consumed without effect. Every fifth alphabet character
// closes a group, which leaves the block as four byte beats, most significant
// first, the fourth marked last; a group above 32 bits leaves as one overflow
// beat instead, and a character outside the alphabet leaves as one error beat
// and drops the partial group. Output beats pass at one per cycle, while
// out_ready is high, through a registered output stage: the first beat for a
// closing character is written into the event queue and then into the output
// register before it is offered. No clearing is needed after reset.
module z85_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic       group_last,
	output logic [1:0] status
);

	z85_pkg::q_stat_t q_stat;
	z85_pkg::event_t  push_ev;
	z85_pkg::event_t  head_ev;
	logic             push;
	logic             pop;

	z85_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_in  (char_in),
		.q_stat   (q_stat),
		.push     (push),
		.push_ev  (push_ev)
	);

	z85_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (push_ev),
		.pop     (pop),
		.head_ev (head_ev),
		.q_stat  (q_stat)
	);

	z85_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_ev    (head_ev),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_out   (byte_out),
		.group_last (group_last),
		.status     (status)
	);

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Z85 stream decoder
module testbench;

	class z85_scoreboard;
		typedef struct packed {
			logic [7:0]         data;
			logic               last;
			z85_pkg::status_t   code;
		} beat_t;

		string       alphabet;
		int          digit_of [256];
		logic [25:0] partial;
		int unsigned ndigits;
		beat_t       beats_due [$];
		int          mismatches;

		function new();
			alphabet = {"0123456789abcdefghijklmnopqrstuvwxyz",
				"ABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#"};
			foreach (digit_of[i]) digit_of[i] = -1;
			for (int i = 0; i < alphabet.len(); i++) digit_of[alphabet[i]] = i;
			partial    = '0;
			ndigits    = 0;
			mismatches = 0;
		endfunction

		function logic [7:0] char_of(int d);
			return alphabet[d];
		endfunction

		function int pending();
			return beats_due.size();
		endfunction

		function void push_beat(logic [7:0] data, logic last, z85_pkg::status_t code);
			beat_t b;
			b.data = data;
			b.last = last;
			b.code = code;
			beats_due.push_back(b);
		endfunction

		// Fold one accepted character into the group and queue the beats it causes
		function void take_char(logic [7:0] ch);
			logic [35:0] acc;
			int          d;
			if (ch == z85_pkg::NEWLINE) return;
			d = digit_of[ch];
			if (d < 0) begin
				partial = '0;
				ndigits = 0;
				push_beat(8'h00, 1'b1, z85_pkg::ST_BAD_CHAR);
				return;
			end
			acc = 36'(partial) * 36'(z85_pkg::BASE) + 36'(d);
			if (ndigits < z85_pkg::LAST_DIGIT) begin
				partial = acc[25:0];
				ndigits++;
				return;
			end
			partial = '0;
			ndigits = 0;
			if (acc > 36'hFFFF_FFFF) begin
				push_beat(8'h00, 1'b1, z85_pkg::ST_OVERFLOW);
				return;
			end
			for (int k = 0; k < 4; k++)
				push_beat(acc[31 - 8 * k -: 8], k == 3, z85_pkg::ST_DATA);
		endfunction

		function void check_beat(logic [7:0] data, logic last, logic [1:0] code);
			beat_t want;
			if (beats_due.size() == 0) begin
				$display("%0t: beat with none due: byte %h last %b status %0d",
					$time, data, last, code);
				mismatches++;
				return;
			end
			want = beats_due.pop_front();
			if (data !== want.data) begin
				$display("%0t: byte_out expected %h actual %h", $time, want.data, data);
				mismatches++;
			end
			if (last !== want.last) begin
				$display("%0t: group_last expected %b actual %b", $time, want.last, last);
				mismatches++;
			end
			if (code !== want.code) begin
				$display("%0t: status expected %0d actual %0d", $time, want.code, code);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] char_in   = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] byte_out;
	logic       group_last;
	logic [1:0] status;

	z85_scoreboard sb = new();

	int tx_idle_pct = 23;
	int rx_idle_pct = 46;
	int hold_req    = 0;
	int hold_left   = 0;
	int chars_sent  = 0;

	z85_stream_decoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_in    (char_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_out   (byte_out),
		.group_last (group_last),
		.status     (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: random back-pressure, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req > 0) begin
			hold_left = hold_req - 1;
			hold_req  = 0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat(byte_out, group_last, status);
	end

	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in  <= c;
		do @(posedge clk); while (!in_ready);
		sb.take_char(c);
		if (c != z85_pkg::NEWLINE) chars_sent++;
	endtask

	// Complete the current group with random digits, now and then a newline between
	task automatic send_group();
		logic [7:0] c;
		for (int i = sb.ndigits; i <= z85_pkg::LAST_DIGIT; i++) begin
			if ($urandom_range(7) == 0) send_char(z85_pkg::NEWLINE);
			// bias the leading digit high so that overflow is reached often
			if (i == 0 && $urandom_range(3) == 0)
				c = sb.char_of($urandom_range(84, 81));
			else
				c = sb.char_of($urandom_range(84));
			send_char(c);
		end
	endtask

	// Start a group and break it off with a character outside the alphabet
	task automatic send_broken();
		logic [7:0] c;
		int         n;
		n = $urandom_range(4, 1);
		repeat (n) send_char(sb.char_of($urandom_range(84)));
		do c = 8'($urandom_range(255));
		while (sb.digit_of[c] >= 0 || c == z85_pkg::NEWLINE);
		send_char(c);
	endtask

	task automatic run_phase(input int n);
		int start;
		int r;
		start = chars_sent;
		while (chars_sent - start < n) begin
			r = $urandom_range(99);
			if (r < 70)
				send_group();
			else if (r < 85)
				send_broken();
			else
				send_char(8'($urandom_range(255)));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		string directed;
		directed = "00000%nSc0%nSc1He\nlloab|";
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero group, largest group, one past it, newline mid-group, broken group
		for (int i = 0; i < directed.len(); i++) send_char(directed[i]);
		send_char(8'h00);
		send_char(8'hFF);

		// hold the output long enough for the block to stall its input
		hold_req = 60;
		run_phase(40);
		drain();

		tx_idle_pct = 46;
		rx_idle_pct = 23;
		run_phase(24);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(24);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

endmodule
